// ----- hw/rtl/h_bridge_speed_ramp_core_assert.svh -----
// assertion macros shared by the speed ramp rtl
`ifndef H_BRIDGE_SPEED_RAMP_CORE_ASSERT_SVH
`define H_BRIDGE_SPEED_RAMP_CORE_ASSERT_SVH

// condition holds at every edge outside reset
`define HBSR_ASSERT_HOLDS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("hbsr: invariant violated");

// consequent holds in the same cycle as the antecedent
`define HBSR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hbsr: implication violated");

// consequent holds in the cycle after the antecedent
`define HBSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hbsr: next-cycle check violated");

`endif

// ----- hw/rtl/hbsr_pkg.sv -----
package hbsr_pkg;

   localparam int SPEED_W      = 16;
   localparam int SPEED_EXT_W  = 17;
   localparam int START_W      = 9;
   localparam int INC_W        = 10;
   localparam int TICK_W       = 10;
   localparam int DUTY_W       = 8;
   localparam int CMD_W        = 8;
   localparam int MODE_CODE_W  = 2;

   localparam int RAMP_STEPS_DEFAULT = 100;
   localparam logic [TICK_W-1:0] STEP_TICKS_RESET = 10'd10;
   localparam logic [TICK_W-1:0] TICK_MAX         = 10'd1023;

   localparam logic signed [SPEED_W-1:0] SPEED_MAX        = 16'sd25599;
   localparam logic signed [SPEED_W-1:0] SPEED_STEP_LIMIT = 16'sd25500;
   localparam logic signed [SPEED_W-1:0] CENTI            = 16'sd100;

   // reciprocal of 100 for values below 2**15, shift 22
   localparam logic [15:0] DIV100_MUL = 16'd41944;

   localparam logic [CMD_W-1:0] CMD_CW    = 8'h57;   // W
   localparam logic [CMD_W-1:0] CMD_CCW   = 8'h53;   // S
   localparam logic [CMD_W-1:0] CMD_STOP  = 8'h58;   // X
   localparam logic [CMD_W-1:0] CMD_HALT  = 8'h50;   // P
   localparam logic [CMD_W-1:0] CMD_UP    = 8'h59;   // Y
   localparam logic [CMD_W-1:0] CMD_DOWN  = 8'h48;   // H

   localparam logic [MODE_CODE_W-1:0] MODE_CODE_CW   = 2'd0;
   localparam logic [MODE_CODE_W-1:0] MODE_CODE_CCW  = 2'd1;
   localparam logic [MODE_CODE_W-1:0] MODE_CODE_STOP = 2'd2;

   typedef enum logic [2:0] {
      MODE_CW   = 3'b001,
      MODE_CCW  = 3'b010,
      MODE_STOP = 3'b100
   } mode_type;

   typedef enum logic [2:0] {
      PH_INIT  = 3'b001,
      PH_TRANS = 3'b010,
      PH_DONE  = 3'b100
   } phase_type;

   typedef struct packed {
      mode_type  mode;
      phase_type cw_phase;
      phase_type ccw_phase;
      phase_type stop_phase;
      logic      brake;
   } ctl_type;

   function automatic logic [DUTY_W-1:0] div100(input logic [14:0] mag);
      logic [30:0] prod;
      prod = 31'(mag) * 31'(DIV100_MUL);
      return prod[29:22];
   endfunction

   function automatic logic signed [SPEED_W-1:0] sat_speed(
      input logic signed [SPEED_EXT_W-1:0] v);
      logic signed [SPEED_W-1:0] res;
      if (v > SPEED_EXT_W'(SPEED_MAX)) begin
         res = SPEED_MAX;
      end else if (v < -SPEED_EXT_W'(SPEED_MAX)) begin
         res = -SPEED_MAX;
      end else begin
         res = v[SPEED_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [MODE_CODE_W-1:0] mode_code(input mode_type m);
      logic [MODE_CODE_W-1:0] code;
      case (m)
         MODE_CW:  code = MODE_CODE_CW;
         MODE_CCW: code = MODE_CODE_CCW;
         default:  code = MODE_CODE_STOP;
      endcase
      return code;
   endfunction

endpackage

// ----- hw/rtl/hbsr_pass.sv -----
module hbsr_pass
   import hbsr_pkg::*;
#(
   parameter int RAMP_STEPS = RAMP_STEPS_DEFAULT,
   parameter int STEP_W     = $clog2(RAMP_STEPS + 1)
) (
   input  ctl_type                    ctl,
   input  logic signed [SPEED_W-1:0]  speed,
   input  logic signed [START_W-1:0]  start_speed,
   input  logic signed [INC_W-1:0]    ramp_inc,
   input  logic [STEP_W-1:0]          step_count,
   input  logic [TICK_W-1:0]          elapsed,
   input  logic [TICK_W-1:0]          step_ticks,
   input  logic                       tick,
   input  logic                       cmd_valid,
   input  logic [CMD_W-1:0]           command,
   output ctl_type                    ctl_next,
   output logic signed [SPEED_W-1:0]  speed_next,
   output logic signed [START_W-1:0]  start_speed_next,
   output logic signed [INC_W-1:0]    ramp_inc_next,
   output logic [STEP_W-1:0]          step_count_next,
   output logic [TICK_W-1:0]          elapsed_next,
   output logic [DUTY_W-1:0]          duty,
   output logic                       ramping
);

   // per-step increment = ramp_inc*100/RAMP_STEPS via reciprocal, exact below 2**16
   localparam int     DIV_L = $clog2(RAMP_STEPS);
   localparam int     DIV_S = 16 + DIV_L;
   localparam longint DIV_M = ((longint'(1) << DIV_S) + RAMP_STEPS - 1) / RAMP_STEPS;
   localparam logic [17:0] DIV_MUL = 18'(DIV_M);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RAMP_STEPS);

   logic [INC_W-1:0]                inc_mag;
   logic [15:0]                     inc_x100;
   logic [33:0]                     delta_prod;
   logic [15:0]                     delta_mag;
   logic signed [SPEED_EXT_W-1:0]   delta;

   logic [TICK_W-1:0]               elapsed_tick;
   ctl_type                         ctl_cmd;
   logic signed [SPEED_W-1:0]       speed_cmd;
   logic signed [SPEED_EXT_W-1:0]   speed_req;
   logic                            speed_upd;
   logic                            ramping_cmd;

   phase_type                       phase_cur;
   phase_type                       phase_new;
   logic                            to_zero;
   logic [14:0]                     cmd_mag;
   logic [DUTY_W-1:0]               start_mag;
   logic signed [START_W-1:0]       start_calc;
   logic signed [SPEED_W-1:0]       target;
   logic signed [SPEED_W-1:0]       speed_step;
   logic [STEP_W-1:0]               step_inc;
   logic [14:0]                     out_mag;

   always_comb begin
      inc_mag    = ramp_inc[INC_W-1] ? -ramp_inc : ramp_inc;
      inc_x100   = 16'(inc_mag) * 16'd100;
      delta_prod = 34'(inc_x100) * 34'(DIV_MUL);
      delta_mag  = 16'(delta_prod >> DIV_S);
      delta      = ramp_inc[INC_W-1] ? -SPEED_EXT_W'(delta_mag) : SPEED_EXT_W'(delta_mag);
   end

   always_comb begin
      if (tick && elapsed != TICK_MAX) begin
         elapsed_tick = elapsed + 1'b1;
      end else begin
         elapsed_tick = elapsed;
      end

      // command stage
      ctl_cmd   = ctl;
      speed_cmd = speed;
      speed_req = '0;
      speed_upd = 1'b0;
      if (cmd_valid) begin
         case (command)
            CMD_CW: begin
               if (ctl.mode != MODE_CW) begin
                  ctl_cmd.mode     = MODE_CW;
                  ctl_cmd.cw_phase = PH_INIT;
               end
            end
            CMD_CCW: begin
               if (ctl.mode != MODE_CCW) begin
                  ctl_cmd.mode      = MODE_CCW;
                  ctl_cmd.ccw_phase = PH_INIT;
               end
            end
            CMD_STOP: begin
               if (ctl.mode != MODE_STOP) begin
                  ctl_cmd.mode       = MODE_STOP;
                  ctl_cmd.stop_phase = PH_INIT;
               end
            end
            CMD_HALT: begin
               ctl_cmd.mode       = MODE_STOP;
               ctl_cmd.stop_phase = PH_DONE;
               ctl_cmd.brake      = 1'b0;
               speed_cmd          = '0;
            end
            CMD_UP: begin
               if (speed < SPEED_STEP_LIMIT) begin
                  speed_upd = 1'b1;
                  speed_req = SPEED_EXT_W'(speed) + SPEED_EXT_W'(CENTI);
               end
            end
            CMD_DOWN: begin
               if (speed > -SPEED_STEP_LIMIT) begin
                  speed_upd = 1'b1;
                  speed_req = SPEED_EXT_W'(speed) - SPEED_EXT_W'(CENTI);
               end
            end
            default: begin
            end
         endcase
      end

      ramping_cmd = (ctl_cmd.cw_phase == PH_TRANS) || (ctl_cmd.ccw_phase == PH_TRANS) ||
                    (ctl_cmd.stop_phase == PH_TRANS);
      if (speed_upd) begin
         speed_cmd     = sat_speed(speed_req);
         ctl_cmd.brake = 1'b0;
         // with no ramp under way the mode follows the sign of the speed
         if (!ramping_cmd) begin
            if (speed_cmd > 0 && ctl_cmd.mode != MODE_CW) begin
               ctl_cmd.mode     = MODE_CW;
               ctl_cmd.cw_phase = PH_DONE;
            end else if (speed_cmd == 0 && ctl_cmd.mode != MODE_STOP) begin
               ctl_cmd.mode       = MODE_STOP;
               ctl_cmd.stop_phase = PH_DONE;
            end else if (speed_cmd < 0 && ctl_cmd.mode != MODE_CCW) begin
               ctl_cmd.mode      = MODE_CCW;
               ctl_cmd.ccw_phase = PH_DONE;
            end
         end
      end

      // phase stage for the current mode
      case (ctl_cmd.mode)
         MODE_CW:  phase_cur = ctl_cmd.cw_phase;
         MODE_CCW: phase_cur = ctl_cmd.ccw_phase;
         default:  phase_cur = ctl_cmd.stop_phase;
      endcase
      to_zero = (ctl_cmd.mode == MODE_STOP);

      cmd_mag    = speed_cmd[SPEED_W-1] ? 15'(-speed_cmd) : speed_cmd[14:0];
      start_mag  = div100(cmd_mag);
      start_calc = speed_cmd[SPEED_W-1] ? -START_W'(start_mag) : START_W'(start_mag);
      target     = to_zero ? '0 :
                   -({{(SPEED_W-START_W){start_speed[START_W-1]}}, start_speed} * CENTI);
      speed_step = sat_speed(SPEED_EXT_W'(speed_cmd) + delta);
      step_inc   = step_count + 1'b1;

      ctl_next         = ctl_cmd;
      phase_new        = phase_cur;
      speed_next       = speed_cmd;
      start_speed_next = start_speed;
      ramp_inc_next    = ramp_inc;
      step_count_next  = step_count;
      elapsed_next     = elapsed_tick;

      case (phase_cur)
         PH_INIT: begin
            start_speed_next = start_calc;
            ramp_inc_next    = to_zero ? -{start_calc[START_W-1], start_calc} :
                                         -{start_calc, 1'b0};
            elapsed_next     = '0;
            step_count_next  = '0;
            phase_new        = PH_TRANS;
         end
         PH_TRANS: begin
            if (elapsed_tick >= step_ticks) begin
               elapsed_next    = '0;
               step_count_next = step_inc;
               ctl_next.brake  = 1'b0;
               if (step_inc >= STEP_LAST) begin
                  speed_next = target;
                  phase_new  = PH_DONE;
               end else begin
                  speed_next = speed_step;
               end
            end
         end
         default: begin
         end
      endcase

      case (ctl_cmd.mode)
         MODE_CW:  ctl_next.cw_phase   = phase_new;
         MODE_CCW: ctl_next.ccw_phase  = phase_new;
         default:  ctl_next.stop_phase = phase_new;
      endcase

      out_mag = speed_next[SPEED_W-1] ? 15'(-speed_next) : speed_next[14:0];
      duty    = div100(out_mag);
      ramping = (ctl_next.cw_phase == PH_TRANS) || (ctl_next.ccw_phase == PH_TRANS) ||
                (ctl_next.stop_phase == PH_TRANS);
   end

endmodule

// ----- hw/rtl/h_bridge_speed_ramp_core.sv -----
// H-bridge speed ramp with soft reversal. Each request is one control pass
// carrying an optional 1 ms tick and an optional ASCII command (W cw, S ccw,
// X stop, P halt, Y up, H down); each request gives exactly one response with
// the PWM duty, drive direction, brake, signed speed in hundredths, mode and
// ramp flag. A W, S or X command that changes the mode ramps the speed
// linearly over RAMP_STEPS steps, one step every csr_step_ticks ticks. The
// block takes one request per clock cycle unless rsp_stall holds a response;
// a request waits in the request register, then one update pass writes the
// response register. The controller state lives in registers updated on that
// pass, so consecutive passes need no spacing. csr_step_ticks is always ready
// and should only be written while no request is in flight.
`include "h_bridge_speed_ramp_core_assert.svh"

module h_bridge_speed_ramp_core
   import hbsr_pkg::*;
#(
   parameter int RAMP_STEPS = RAMP_STEPS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_tick,
   input  logic                       req_cmd_valid,
   input  logic [CMD_W-1:0]           req_command,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [DUTY_W-1:0]          rsp_duty,
   output logic                       rsp_reverse_drive,
   output logic                       rsp_brake,
   output logic signed [SPEED_W-1:0]  rsp_speed_centi,
   output logic [MODE_CODE_W-1:0]     rsp_motor_mode,
   output logic                       rsp_ramping,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [TICK_W-1:0]          csr_step_ticks
);

   localparam int STEP_W = $clog2(RAMP_STEPS + 1);

   // request register
   logic                       req_full_ff, req_full_in;
   logic                       tick_ff;
   logic                       cmd_valid_ff;
   logic [CMD_W-1:0]           command_ff;

   // controller state
   ctl_type                    ctl_ff, ctl_in;
   logic signed [SPEED_W-1:0]  speed_ff, speed_in;
   logic signed [START_W-1:0]  start_speed_ff, start_speed_in;
   logic signed [INC_W-1:0]    ramp_inc_ff, ramp_inc_in;
   logic [STEP_W-1:0]          step_count_ff, step_count_in;
   logic [TICK_W-1:0]          elapsed_ff, elapsed_in;
   logic [TICK_W-1:0]          step_ticks_ff;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]          duty_ff, duty_in;
   logic                       brake_ff;
   logic [MODE_CODE_W-1:0]     motor_mode_ff;
   logic                       ramping_ff, ramping_in;

   logic                       advance;
   logic                       req_take;

   assign advance     = req_full_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = req_full_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign req_full_in = req_take || (req_full_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   hbsr_pass #(
      .RAMP_STEPS (RAMP_STEPS),
      .STEP_W     (STEP_W)
   ) u_pass (
      .ctl              (ctl_ff),
      .speed            (speed_ff),
      .start_speed      (start_speed_ff),
      .ramp_inc         (ramp_inc_ff),
      .step_count       (step_count_ff),
      .elapsed          (elapsed_ff),
      .step_ticks       (step_ticks_ff),
      .tick             (tick_ff),
      .cmd_valid        (cmd_valid_ff),
      .command          (command_ff),
      .ctl_next         (ctl_in),
      .speed_next       (speed_in),
      .start_speed_next (start_speed_in),
      .ramp_inc_next    (ramp_inc_in),
      .step_count_next  (step_count_in),
      .elapsed_next     (elapsed_in),
      .duty             (duty_in),
      .ramping          (ramping_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         step_ticks_ff  <= STEP_TICKS_RESET;
         ctl_ff         <= '{mode: MODE_STOP, cw_phase: PH_INIT, ccw_phase: PH_INIT,
                             stop_phase: PH_DONE, brake: 1'b1};
         speed_ff       <= '0;
         start_speed_ff <= '0;
         ramp_inc_ff    <= '0;
         step_count_ff  <= '0;
         elapsed_ff     <= '0;
      end else begin
         req_full_ff  <= req_full_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            step_ticks_ff <= csr_step_ticks;
         end
         if (advance) begin
            ctl_ff         <= ctl_in;
            speed_ff       <= speed_in;
            start_speed_ff <= start_speed_in;
            ramp_inc_ff    <= ramp_inc_in;
            step_count_ff  <= step_count_in;
            elapsed_ff     <= elapsed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_ff      <= req_tick;
         cmd_valid_ff <= req_cmd_valid;
         command_ff   <= req_command;
      end
      if (advance) begin
         duty_ff       <= duty_in;
         brake_ff      <= ctl_in.brake;
         motor_mode_ff <= mode_code(ctl_in.mode);
         ramping_ff    <= ramping_in;
      end
   end

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_duty          = duty_ff;
   // speed register holds the value of the last pass, which is what the response shows
   assign rsp_speed_centi   = speed_ff;
   assign rsp_reverse_drive = speed_ff[SPEED_W-1];
   assign rsp_brake         = brake_ff;
   assign rsp_motor_mode    = motor_mode_ff;
   assign rsp_ramping       = ramping_ff;

   `HBSR_ASSERT_NEXT(a_brake_stays_released, clock, reset, !ctl_ff.brake, !ctl_ff.brake)
   `HBSR_ASSERT_HOLDS(a_speed_in_range, clock, reset, (speed_ff <= SPEED_MAX) && (speed_ff >= -SPEED_MAX))
   `HBSR_ASSERT_HOLDS(a_step_count_bounded, clock, reset, step_count_ff <= STEP_W'(RAMP_STEPS))
   `HBSR_ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, req_stall, req_full_ff && rsp_valid_ff)
   `HBSR_ASSERT_NEXT(a_state_held_without_pass, clock, reset, !advance, $stable(speed_ff) && $stable(ctl_ff))

endmodule
